[rtl/aabb_pkg.sv]
package aabb_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int FACE_W  = 3;
	localparam int AXES_MAX = 3;
	localparam int DIMENSIONS_DEF = 3;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_LOWER_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_Z = 3'd5;

	localparam logic signed [COORD_W-1:0] LOWER_RST = 32'sd0;
	localparam logic signed [COORD_W-1:0] UPPER_RST = 32'sd65536;

	localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
	localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd1;
	localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd2;
	localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd3;
	localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

	localparam logic [FACE_W-1:0] FACE_POS [AXES_MAX] = '{FACE_POS_X, FACE_POS_Y, FACE_POS_Z};
	localparam logic [FACE_W-1:0] FACE_NEG [AXES_MAX] = '{FACE_NEG_X, FACE_NEG_Y, FACE_NEG_Z};

	localparam int S_TDATA_W = AXES_MAX * COORD_W;
	localparam int FACE_LSB  = AXES_MAX * COORD_W;
	localparam int INSIDE_BIT = FACE_LSB + FACE_W;
	localparam int M_BITS    = INSIDE_BIT + 1;
	localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8;
	localparam int M_PAD_W   = M_TDATA_W - M_BITS;

	typedef struct packed {
		logic [FACE_W-1:0] face;
		logic [DIFF_W-1:0] key;
	} cand_t;

endpackage

[rtl/aabb_closest_point_and_normal_unit.sv]
// Closest point on an axis-aligned box surface, with the outward face normal.
// Input stream s_*: one query point per item, signed Q16.16 per axis.
// Output stream m_*: near point, face index (0..2 = +x,+y,+z, 3..5 = -x,-y,-z)
// and an inside flag, one result item per input item, in order.
// Box corners come from the write port (cfg_we/cfg_index/cfg_data); each axis
// is ordered min/max, so the corners may be written in either order. Write
// only while the pipeline is empty. Indexes above five are ignored.
// Six register stages: corner ordering, bound differences, clamp and face keys,
// pairwise face compare, final face pick, near-point select. One item per cycle
// is sustained while m_tready is high.
// Each stage has its own valid bit and a stage loads when it is empty or its
// successor loads, so bubbles close up and a stall of m_tready holds every
// item in place; s_tready drops only once all six stages are full.
// Reset empties the pipeline and loads the corners (0,0,0) and (1,1,1).
// DIMENSIONS = 2 uses x and y only: near_z is 0, faces 2 and 5 never win.
module aabb_closest_point_and_normal_unit #(
	parameter int DIMENSIONS = aabb_pkg::DIMENSIONS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [aabb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [aabb_pkg::COORD_W-1:0]        cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// point_x, point_y, point_z
	input  logic [aabb_pkg::S_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// near_x, near_y, near_z, face_index, inside_res, zero pad
	output logic [aabb_pkg::M_TDATA_W-1:0]      m_tdata
);

	localparam int AXES = (DIMENSIONS == 2) ? 2 : 3;
	localparam int CW   = aabb_pkg::COORD_W;
	localparam int DW   = aabb_pkg::DIFF_W;
	localparam int NA   = aabb_pkg::AXES_MAX;

	function automatic aabb_pkg::cand_t pick(aabb_pkg::cand_t a, logic a_en,
			aabb_pkg::cand_t b, logic b_en);
		aabb_pkg::cand_t r;
		r = a;
		if (b_en && (!a_en || $signed(b.key) < $signed(a.key)))
			r = b;
		return r;
	endfunction

	logic signed [CW-1:0] lower_q [NA];
	logic signed [CW-1:0] upper_q [NA];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NA; a++) begin
				lower_q[a] <= aabb_pkg::LOWER_RST;
				upper_q[a] <= aabb_pkg::UPPER_RST;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				aabb_pkg::REG_LOWER_X: lower_q[0] <= cfg_data;
				aabb_pkg::REG_LOWER_Y: lower_q[1] <= cfg_data;
				aabb_pkg::REG_LOWER_Z: lower_q[2] <= cfg_data;
				aabb_pkg::REG_UPPER_X: upper_q[0] <= cfg_data;
				aabb_pkg::REG_UPPER_Y: upper_q[1] <= cfg_data;
				aabb_pkg::REG_UPPER_Z: upper_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	assign rdy_s6 = !v_s6 || m_tready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	assign s_tready = rdy_s1;
	assign m_tvalid = v_s6;

	// stage 1: capture point, order corners
	logic signed [CW-1:0] p_s1 [NA];
	logic signed [CW-1:0] lo_s1 [NA];
	logic signed [CW-1:0] hi_s1 [NA];

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			for (int a = 0; a < NA; a++) begin
				p_s1[a] <= s_tdata[a*CW +: CW];
				if (lower_q[a] < upper_q[a]) begin
					lo_s1[a] <= lower_q[a];
					hi_s1[a] <= upper_q[a];
				end else begin
					lo_s1[a] <= upper_q[a];
					hi_s1[a] <= lower_q[a];
				end
			end
		end
	end

	// stage 2: distances to both planes
	logic signed [CW-1:0] p_s2 [NA];
	logic signed [CW-1:0] lo_s2 [NA];
	logic signed [CW-1:0] hi_s2 [NA];
	logic signed [DW-1:0] dhi_s2 [NA];
	logic signed [DW-1:0] dlo_s2 [NA];

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			for (int a = 0; a < NA; a++) begin
				p_s2[a]   <= p_s1[a];
				lo_s2[a]  <= lo_s1[a];
				hi_s2[a]  <= hi_s1[a];
				dhi_s2[a] <= {hi_s1[a][CW-1], hi_s1[a]} - {p_s1[a][CW-1], p_s1[a]};
				dlo_s2[a] <= {p_s1[a][CW-1], p_s1[a]} - {lo_s1[a][CW-1], lo_s1[a]};
			end
		end
	end

	// stage 3: containment, clamp, face keys (least key wins)
	logic [NA-1:0]        below_c, above_c;
	logic                 inside_c;
	logic signed [CW-1:0] clamp_c [NA];
	logic signed [DW-1:0] kpos_c [NA];
	logic signed [DW-1:0] kneg_c [NA];

	always_comb begin
		for (int a = 0; a < NA; a++) begin
			below_c[a] = (a < AXES) && dlo_s2[a][DW-1];
			above_c[a] = (a < AXES) && dhi_s2[a][DW-1];
		end
		inside_c = !(|below_c) && !(|above_c);
		for (int a = 0; a < NA; a++) begin
			if (a >= AXES)
				clamp_c[a] = '0;
			else if (below_c[a])
				clamp_c[a] = lo_s2[a];
			else if (above_c[a])
				clamp_c[a] = hi_s2[a];
			else
				clamp_c[a] = p_s2[a];
			if (inside_c) begin
				kpos_c[a] = dhi_s2[a];
				kneg_c[a] = dlo_s2[a];
			end else if (below_c[a]) begin
				kpos_c[a] = -dlo_s2[a];
				kneg_c[a] = dlo_s2[a];
			end else if (above_c[a]) begin
				kpos_c[a] = dhi_s2[a];
				kneg_c[a] = -dhi_s2[a];
			end else begin
				kpos_c[a] = '0;
				kneg_c[a] = '0;
			end
		end
	end

	logic                 inside_s3;
	logic signed [CW-1:0] p_s3 [NA];
	logic signed [CW-1:0] lo_s3 [NA];
	logic signed [CW-1:0] hi_s3 [NA];
	logic signed [CW-1:0] clamp_s3 [NA];
	aabb_pkg::cand_t      cand_s3 [2*NA];

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			inside_s3 <= inside_c;
			for (int a = 0; a < NA; a++) begin
				p_s3[a]     <= p_s2[a];
				lo_s3[a]    <= lo_s2[a];
				hi_s3[a]    <= hi_s2[a];
				clamp_s3[a] <= clamp_c[a];
				cand_s3[a]    <= '{face: aabb_pkg::FACE_POS[a], key: kpos_c[a]};
				cand_s3[a+NA] <= '{face: aabb_pkg::FACE_NEG[a], key: kneg_c[a]};
			end
		end
	end

	// stage 4: pairwise compare in face order
	localparam logic Z_EN = (AXES == 3);

	logic                 inside_s4;
	logic signed [CW-1:0] p_s4 [NA];
	logic signed [CW-1:0] lo_s4 [NA];
	logic signed [CW-1:0] hi_s4 [NA];
	logic signed [CW-1:0] clamp_s4 [NA];
	aabb_pkg::cand_t      win_s4 [NA];

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			inside_s4 <= inside_s3;
			p_s4      <= p_s3;
			lo_s4     <= lo_s3;
			hi_s4     <= hi_s3;
			clamp_s4  <= clamp_s3;
			win_s4[0] <= pick(cand_s3[0], 1'b1, cand_s3[1], 1'b1);
			win_s4[1] <= pick(cand_s3[2], Z_EN, cand_s3[3], 1'b1);
			win_s4[2] <= pick(cand_s3[4], 1'b1, cand_s3[5], Z_EN);
		end
	end

	// stage 5: final face
	aabb_pkg::cand_t      w01_c, w_c;
	logic                 inside_s5;
	logic signed [CW-1:0] p_s5 [NA];
	logic signed [CW-1:0] lo_s5 [NA];
	logic signed [CW-1:0] hi_s5 [NA];
	logic signed [CW-1:0] clamp_s5 [NA];
	logic [aabb_pkg::FACE_W-1:0] face_s5;

	always_comb begin
		w01_c = pick(win_s4[0], 1'b1, win_s4[1], 1'b1);
		w_c   = pick(w01_c, 1'b1, win_s4[2], 1'b1);
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			inside_s5 <= inside_s4;
			p_s5      <= p_s4;
			lo_s5     <= lo_s4;
			hi_s5     <= hi_s4;
			clamp_s5  <= clamp_s4;
			face_s5   <= w_c.face;
		end
	end

	// stage 6: near point, output register
	logic signed [CW-1:0]        near_s6 [NA];
	logic [aabb_pkg::FACE_W-1:0] face_s6;
	logic                        inside_s6;

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			face_s6   <= face_s5;
			inside_s6 <= inside_s5;
			for (int a = 0; a < NA; a++) begin
				if (a >= AXES)
					near_s6[a] <= '0;
				else if (!inside_s5)
					near_s6[a] <= clamp_s5[a];
				else if (face_s5 == aabb_pkg::FACE_POS[a])
					near_s6[a] <= hi_s5[a];
				else if (face_s5 == aabb_pkg::FACE_NEG[a])
					near_s6[a] <= lo_s5[a];
				else
					near_s6[a] <= p_s5[a];
			end
		end
	end

	assign m_tdata = {{aabb_pkg::M_PAD_W{1'b0}}, inside_s6, face_s6,
		near_s6[2], near_s6[1], near_s6[0]};

endmodule

[rtl/aabb_checker.sv]
module aabb_checker #(
	parameter int DIMENSIONS = aabb_pkg::DIMENSIONS_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [aabb_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int CW = aabb_pkg::COORD_W;
	localparam int FL = aabb_pkg::FACE_LSB;

	logic [aabb_pkg::FACE_W-1:0] face;
	assign face = m_tdata[FL +: aabb_pkg::FACE_W];

	// a free output side never blocks the input side
	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("s_tready low while m_tready high");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (face == aabb_pkg::FACE_POS_X || face == aabb_pkg::FACE_POS_Y ||
			face == aabb_pkg::FACE_POS_Z || face == aabb_pkg::FACE_NEG_X ||
			face == aabb_pkg::FACE_NEG_Y || face == aabb_pkg::FACE_NEG_Z))
		else $error("face index out of range");

	a_flat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && DIMENSIONS == 2) |->
			(m_tdata[2*CW +: CW] == '0 && face != aabb_pkg::FACE_POS_Z &&
			face != aabb_pkg::FACE_NEG_Z))
		else $error("z used in two-dimensional mode");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled item changed");

endmodule

bind aabb_closest_point_and_normal_unit aabb_checker #(
	.DIMENSIONS(DIMENSIONS)
) u_aabb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
